// File: hw/rtl/tmps_pkg.sv
// Shared types, codes and constants for the timed motion pattern sequencer.
// No dependencies; imported by every module of the block.
package tmps_pkg;

	// Shared multiplier geometry
	localparam int MUL_W  = 24;
	localparam int PROD_W = 2 * MUL_W;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_HOVER_HEIGHT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALT_GAIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALT_TOL       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FWD_SPEED     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SINE_AMP      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SINE_STEP     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPIRAL_SLOPE  = 3'd7;

	localparam logic [11:0] RST_HOVER_HEIGHT = 12'd512;
	localparam logic [11:0] RST_ALT_GAIN     = 12'd256;
	localparam logic [7:0]  RST_ALT_TOL      = 8'd26;
	localparam logic [9:0]  RST_TURN_RATE    = 10'd128;
	localparam logic [10:0] RST_FWD_SPEED    = 11'd128;
	localparam logic [9:0]  RST_SINE_AMP     = 10'd256;
	localparam logic [15:0] RST_SINE_STEP    = 16'd655;
	localparam logic [10:0] RST_SPIRAL_SLOPE = 11'd26;

	// Pattern phases
	localparam logic [2:0] PH_CLIMB   = 3'd0;
	localparam logic [2:0] PH_TURN_A  = 3'd1;
	localparam logic [2:0] PH_SINE_XY = 3'd2;
	localparam logic [2:0] PH_TURN_B  = 3'd3;
	localparam logic [2:0] PH_SPIRAL  = 3'd4;
	localparam logic [2:0] PH_TURN_C  = 3'd5;
	localparam logic [2:0] PH_SINE_Z  = 3'd6;
	localparam logic [2:0] PH_HOVER   = 3'd7;

	// x/10 == (x * DIV10_RECIP) >> DIV10_SHIFT, exact for x below 699050
	localparam logic [MUL_W-1:0] DIV10_RECIP = 24'd419431;
	localparam int               DIV10_SHIFT = 22;

	// spiral ramp magnitude clip; anything above saturates the output anyway
	localparam logic [18:0] SPIRAL_MAG_MAX = 19'h7FFFF;

	typedef struct packed {
		logic [11:0] hover_height;
		logic [11:0] altitude_gain;
		logic [7:0]  altitude_tolerance;
		logic [9:0]  turn_rate;
		logic [10:0] forward_speed;
		logic [9:0]  sine_amplitude;
		logic [15:0] sine_phase_step;
		logic [10:0] spiral_slope;
	} cfg_t;

	// quarter-wave sine, Q1.14, 16 segments plus the end point
	function automatic logic [14:0] qsine(input logic [4:0] idx);
		logic [14:0] v;
		unique case (idx)
			5'd0:    v = 15'd0;
			5'd1:    v = 15'd1606;
			5'd2:    v = 15'd3196;
			5'd3:    v = 15'd4756;
			5'd4:    v = 15'd6270;
			5'd5:    v = 15'd7723;
			5'd6:    v = 15'd9102;
			5'd7:    v = 15'd10394;
			5'd8:    v = 15'd11585;
			5'd9:    v = 15'd12665;
			5'd10:   v = 15'd13623;
			5'd11:   v = 15'd14449;
			5'd12:   v = 15'd15137;
			5'd13:   v = 15'd15679;
			5'd14:   v = 15'd16069;
			5'd15:   v = 15'd16305;
			5'd16:   v = 15'd16384;
			default: v = 15'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767)
			r = 16'sh7FFF;
		else if (v < -20'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

// File: hw/rtl/tmps_cfg.sv
// Configuration register file of the motion pattern sequencer.
// Depends on tmps_pkg for the register indexes, reset values and cfg_t.
module tmps_cfg import tmps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hover_height       <= RST_HOVER_HEIGHT;
			cfg_q.altitude_gain      <= RST_ALT_GAIN;
			cfg_q.altitude_tolerance <= RST_ALT_TOL;
			cfg_q.turn_rate          <= RST_TURN_RATE;
			cfg_q.forward_speed      <= RST_FWD_SPEED;
			cfg_q.sine_amplitude     <= RST_SINE_AMP;
			cfg_q.sine_phase_step    <= RST_SINE_STEP;
			cfg_q.spiral_slope       <= RST_SPIRAL_SLOPE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HOVER_HEIGHT: cfg_q.hover_height       <= cfg_data[11:0];
				CFG_ALT_GAIN:     cfg_q.altitude_gain      <= cfg_data[11:0];
				CFG_ALT_TOL:      cfg_q.altitude_tolerance <= cfg_data[7:0];
				CFG_TURN_RATE:    cfg_q.turn_rate          <= cfg_data[9:0];
				CFG_FWD_SPEED:    cfg_q.forward_speed      <= cfg_data[10:0];
				CFG_SINE_AMP:     cfg_q.sine_amplitude     <= cfg_data[9:0];
				CFG_SINE_STEP:    cfg_q.sine_phase_step    <= cfg_data[15:0];
				CFG_SPIRAL_SLOPE: cfg_q.spiral_slope       <= cfg_data[10:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/tmps_mul.sv
// Shared signed multiplier with a registered product.
// Depends on tmps_pkg for the operand width.
module tmps_mul import tmps_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule

// File: hw/rtl/timed_motion_pattern_sequencer.sv
// Timed motion pattern sequencer: eight-phase flight pattern, one Q8.8 velocity
// command per transaction. All products go through one registered multiplier that a
// small sequencer steps through an issue state and a post state for each product.
// A new item is taken only once the sequencer is back in idle, and a stalled output
// holds the sequencer in its post state.
// arst_n clears the phase, tick counter, simulated altitude and output valid, and
// loads the config registers with their defaults.
module timed_motion_pattern_sequencer import tmps_pkg::*; #(
	parameter int unsigned TURN_TICKS          = 20,
	parameter int unsigned SINE_TICKS          = 100,
	parameter int unsigned SPIRAL_TICKS        = 100,
	parameter int unsigned CLIMB_TIMEOUT_TICKS = 30,
	parameter int          SPIRAL_START_SPEED  = 128,
	parameter int          SPIRAL_START_TURN   = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [3:0]            ticks,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    vel_x,
	output logic signed [15:0]    vel_y,
	output logic signed [15:0]    vel_z,
	output logic signed [15:0]    yaw_rate,
	output logic [2:0]            phase
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_POST = 3'b100
	} state_t;

	cfg_t cfg;

	state_t             state_q;
	logic [1:0]         step_q;
	logic [2:0]         pattern_q;
	logic [15:0]        tip_q;
	logic signed [15:0] alt_q;
	logic               out_valid_q;

	logic [15:0]        e_q;
	logic               neg_q;
	logic [20:0]        mag_q;
	logic signed [8:0]  qv_q;
	logic [14:0]        base_q;
	logic [10:0]        diff_q;
	logic [9:0]         frac_q;
	logic signed [15:0] vel_x_q, vel_y_q, vel_z_q, yaw_q;
	logic [2:0]         phase_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_s1;

	tmps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tmps_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	// saturating elapsed time
	logic [16:0] e_sum;
	logic [15:0] e_sat;
	assign e_sum = {1'b0, tip_q} + {13'd0, ticks};
	assign e_sat = e_sum[16] ? 16'hFFFF : e_sum[15:0];

	// altitude error
	logic signed [17:0] err;
	logic [17:0]        aerr;
	assign err  = $signed({6'd0, cfg.hover_height}) - $signed({{2{alt_q[15]}}, alt_q});
	assign aerr = err[17] ? 18'(-err) : 18'(err);

	logic [1:0] last_step;
	always_comb begin
		unique case (pattern_q)
			PH_CLIMB, PH_SPIRAL:   last_step = 2'd1;
			PH_SINE_XY, PH_SINE_Z: last_step = 2'd2;
			default:               last_step = 2'd0;
		endcase
	end

	// multiplier operand selection
	logic [MUL_W-1:0] div10_x;
	assign div10_x = {3'd0, mag_q} + 24'd5;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (pattern_q)
			PH_CLIMB: begin
				if (step_q == 2'd0) begin
					mul_a = {{(MUL_W-18){err[17]}}, err};
					mul_b = {12'd0, cfg.altitude_gain};
				end else begin
					mul_a = div10_x;
					mul_b = DIV10_RECIP;
				end
			end
			PH_SPIRAL: begin
				if (step_q == 2'd0) begin
					mul_a = {{(MUL_W-11){cfg.spiral_slope[10]}}, cfg.spiral_slope};
					mul_b = {8'd0, e_q};
				end else begin
					mul_a = div10_x;
					mul_b = DIV10_RECIP;
				end
			end
			PH_SINE_XY, PH_SINE_Z: begin
				if (step_q == 2'd0) begin
					mul_a = {8'd0, cfg.sine_phase_step};
					mul_b = {8'd0, e_q};
				end else if (step_q == 2'd1) begin
					mul_a = {13'd0, diff_q};
					mul_b = {14'd0, frac_q};
				end else begin
					mul_a = {14'd0, cfg.sine_amplitude};
					mul_b = {3'd0, mag_q};
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// climb: floor(gain*err/256) clamped to +-128
	logic signed [PROD_W-1:0] q_full;
	logic signed [8:0]        q_clamp;
	logic [8:0]               q_abs;
	assign q_full  = prod_s1 >>> 8;
	assign q_clamp = (q_full > 48'sd128)  ?  9'sd128 :
	                 (q_full < -48'sd128) ? -9'sd128 : q_full[8:0];
	assign q_abs   = q_clamp[8] ? 9'(-q_clamp) : 9'(q_clamp);

	// spiral: |slope*e|, clipped
	logic [PROD_W-1:0] sp_abs;
	logic [18:0]       sp_mag;
	assign sp_abs = prod_s1[PROD_W-1] ? PROD_W'(-prod_s1) : PROD_W'(prod_s1);
	assign sp_mag = (sp_abs > {29'd0, SPIRAL_MAG_MAX}) ? SPIRAL_MAG_MAX : sp_abs[18:0];

	// rounded divide by ten, sign restored
	logic [16:0]        d10;
	logic signed [19:0] d10_s;
	assign d10   = prod_s1[DIV10_SHIFT +: 17];
	assign d10_s = neg_q ? -$signed({3'd0, d10}) : $signed({3'd0, d10});

	// sine table lookup
	logic [15:0] sp_p;
	logic [14:0] rr;
	logic [4:0]  rr_idx;
	logic [14:0] tb_base, tb_next;
	logic [10:0] tb_diff;
	assign sp_p    = prod_s1[15:0];
	assign rr      = sp_p[14] ? (15'h4000 - {1'b0, sp_p[13:0]}) : {1'b0, sp_p[13:0]};
	assign rr_idx  = rr[14:10];
	assign tb_base = qsine(rr_idx);
	assign tb_next = qsine(rr_idx + 5'd1);
	assign tb_diff = rr_idx[4] ? 11'd0 : 11'(tb_next - tb_base);

	logic [14:0] s_interp;
	assign s_interp = base_q + {4'd0, prod_s1[20:10]};

	logic [25:0]        sv_rnd;
	logic [9:0]         sv_mag;
	logic signed [15:0] sv;
	assign sv_rnd = {1'b0, prod_s1[24:0]} + 26'd8192;
	assign sv_mag = sv_rnd[23:14];
	assign sv     = neg_q ? -$signed({6'd0, sv_mag}) : $signed({6'd0, sv_mag});

	// results of the final step
	logic signed [15:0] fwd_s;
	logic signed [15:0] alt_next;
	logic signed [15:0] res_x, res_y, res_z, res_w;
	logic               leave;
	assign fwd_s    = {{5{cfg.forward_speed[10]}}, cfg.forward_speed};
	assign alt_next = sat16({{4{alt_q[15]}}, alt_q} + d10_s);

	always_comb begin
		res_x = '0;
		res_y = '0;
		res_z = '0;
		res_w = '0;
		leave = 1'b0;
		unique case (pattern_q)
			PH_CLIMB: begin
				res_z = {{7{qv_q[8]}}, qv_q};
				leave = (aerr < {10'd0, cfg.altitude_tolerance}) ||
				        (e_q > 16'(CLIMB_TIMEOUT_TICKS));
			end
			PH_TURN_A, PH_TURN_B, PH_TURN_C: begin
				res_w = -$signed({6'd0, cfg.turn_rate});
				leave = e_q > 16'(TURN_TICKS);
			end
			PH_SINE_XY: begin
				res_x = fwd_s;
				res_y = sv;
				leave = e_q > 16'(SINE_TICKS);
			end
			PH_SINE_Z: begin
				res_x = fwd_s;
				res_z = sv;
				leave = e_q > 16'(SINE_TICKS);
			end
			PH_SPIRAL: begin
				res_x = sat16($signed(20'(SPIRAL_START_SPEED)) + d10_s);
				res_w = sat16($signed(20'(SPIRAL_START_TURN)) + d10_s);
				leave = e_q > 16'(SPIRAL_TICKS);
			end
			default: begin
				leave = 1'b0;
			end
		endcase
	end

	logic is_last, slot_free, fire;
	assign is_last   = step_q == last_step;
	assign slot_free = !out_valid_q || out_ready;
	assign fire      = (state_q == ST_POST) && is_last && slot_free;
	assign in_ready  = state_q == ST_IDLE;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= 2'd0;
			pattern_q   <= PH_CLIMB;
			tip_q       <= 16'd0;
			alt_q       <= 16'sd0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						step_q  <= 2'd0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_POST;
				end
				ST_POST: begin
					if (!is_last) begin
						step_q  <= step_q + 2'd1;
						state_q <= ST_MUL;
					end else if (slot_free) begin
						if (pattern_q == PH_CLIMB)
							alt_q <= alt_next;
						if (leave) begin
							pattern_q <= pattern_q + 3'd1;
							tip_q     <= 16'd0;
						end else begin
							tip_q <= e_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			e_q <= e_sat;

		if (state_q == ST_POST && !is_last) begin
			unique case (pattern_q)
				PH_CLIMB: begin
					qv_q  <= q_clamp;
					neg_q <= q_clamp[8];
					mag_q <= {12'd0, q_abs};
				end
				PH_SPIRAL: begin
					neg_q <= prod_s1[PROD_W-1];
					mag_q <= {2'd0, sp_mag};
				end
				PH_SINE_XY, PH_SINE_Z: begin
					if (step_q == 2'd0) begin
						neg_q  <= sp_p[15];
						base_q <= tb_base;
						diff_q <= tb_diff;
						frac_q <= rr[9:0];
					end else begin
						mag_q <= {6'd0, s_interp};
					end
				end
				default: begin
					neg_q <= neg_q;
				end
			endcase
		end

		if (fire) begin
			vel_x_q <= res_x;
			vel_y_q <= res_y;
			vel_z_q <= res_z;
			yaw_q   <= res_w;
			phase_q <= leave ? pattern_q + 3'd1 : pattern_q;
		end
	end

	assign out_valid = out_valid_q;
	assign vel_x     = vel_x_q;
	assign vel_y     = vel_y_q;
	assign vel_z     = vel_z_q;
	assign yaw_rate  = yaw_q;
	assign phase     = phase_q;

endmodule

// File: hw/rtl/tmps_checker.sv
// Port-level assertions for the timed motion pattern sequencer, with its bind.
// Depends on tmps_pkg for the phase codes and on the top level's port list.
module tmps_checker import tmps_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] vel_x,
	input logic [15:0] vel_y,
	input logic [15:0] vel_z,
	input logic [15:0] yaw_rate,
	input logic [2:0]  phase
);

	// phase of the last delivered transaction
	logic [2:0] last_phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_phase_q <= PH_CLIMB;
		else if (out_valid && out_ready)
			last_phase_q <= phase;
	end

	// the pattern only ever holds or advances by one
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (phase == last_phase_q || phase == last_phase_q + 3'd1))
		else $error("phase skipped or went back");

	// lateral velocity only from the sideways sine phase or the turn that follows it
	a_vel_y_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && vel_y != 16'd0) |-> (phase == PH_SINE_XY || phase == PH_TURN_B))
		else $error("vel_y driven outside the sideways sine");

	// climb command stays inside the clamp
	a_climb_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && phase == PH_CLIMB) |->
		($signed(vel_z) <= 16'sd128 && $signed(vel_z) >= -16'sd128))
		else $error("climb vel_z outside clamp");

	// a stalled result holds, checked on every output but vel_y
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(vel_x) && $stable(vel_z) && $stable(yaw_rate) && $stable(phase)))
		else $error("output changed while stalled");

	// one transaction at a time: busy right after an input accept
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while busy");

endmodule

bind timed_motion_pattern_sequencer tmps_checker u_tmps_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for timed_motion_pattern_sequencer: directed and random tick transactions,
// random valid/ready gaps and config rewrites while idle, checked by a scoreboard.
// Depends on tmps_pkg and the sequencer RTL.
module tb;
	import tmps_pkg::*;

	localparam int unsigned TURN_TICKS          = 20;
	localparam int unsigned SINE_TICKS          = 100;
	localparam int unsigned SPIRAL_TICKS        = 100;
	localparam int unsigned CLIMB_TIMEOUT_TICKS = 30;
	localparam int          SPIRAL_START_SPEED  = 128;
	localparam int          SPIRAL_START_TURN   = 128;

	localparam int NUM_ITEMS   = 2000;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;

	// register extremes, as written on the config port
	localparam logic [15:0] REG_LO [8] = '{16'd0, 16'd0, 16'd0, 16'd0,
		16'h0400, 16'd0, 16'd0, 16'h0400};
	localparam logic [15:0] REG_HI [8] = '{16'd2560, 16'd4095, 16'd255, 16'd1023,
		16'd1023, 16'd1023, 16'hFFFF, 16'd1023};

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] vz;
		logic signed [15:0] wz;
		logic [2:0]         ph;
	} motion_cmd_t;

	class pattern_scoreboard;
		int unsigned regs [8];
		int unsigned reg_width [8] = '{12, 12, 8, 10, 11, 10, 16, 11};
		int sine_table [17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
			12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};
		logic [2:0] cur_phase;
		int unsigned elapsed;
		int altitude;
		motion_cmd_t expected_cmds [$];
		int errors;

		function new();
			regs = '{RST_HOVER_HEIGHT, RST_ALT_GAIN, RST_ALT_TOL, RST_TURN_RATE,
				RST_FWD_SPEED, RST_SINE_AMP, RST_SINE_STEP, RST_SPIRAL_SLOPE};
			cur_phase = PH_CLIMB;
			elapsed = 0;
			altitude = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			regs[idx] = data & ((32'd1 << reg_width[idx]) - 1);
		endfunction

		function int signed_reg(logic [CFG_IDX_W-1:0] idx);
			if (regs[idx] >= (32'd1 << (reg_width[idx] - 1)))
				return int'(regs[idx]) - (1 << reg_width[idx]);
			return int'(regs[idx]);
		endfunction

		function int clip16(longint v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return int'(v);
		endfunction

		function longint div10_round(longint v);
			if (v >= 0)
				return (v + 5) / 10;
			return -((-v + 5) / 10);
		endfunction

		// quarter-wave lookup with truncated interpolation, scaled by amp
		function int sine_sample(int unsigned amp, int unsigned p);
			int unsigned quad, r, idx, frac;
			int s, v;
			quad = (p >> 14) & 3;
			r = p & 'h3FFF;
			if (quad & 1)
				r = 'h4000 - r;
			idx = r >> 10;
			frac = r & 1023;
			if (idx >= 16)
				s = sine_table[16];
			else
				s = sine_table[idx] +
					(((sine_table[idx + 1] - sine_table[idx]) * int'(frac)) >>> 10);
			v = (int'(amp) * s + 8192) >>> 14;
			return (quad & 2) ? -v : v;
		endfunction

		function void accept_ticks(logic [3:0] t);
			int unsigned e;
			motion_cmd_t c;
			logic [2:0] nxt;
			longint q, r;
			int err, aerr, sv;
			e = elapsed + t;
			if (e > 65535)
				e = 65535;
			c = '0;
			nxt = cur_phase;
			case (cur_phase)
				PH_CLIMB: begin
					err = int'(regs[CFG_HOVER_HEIGHT]) - altitude;
					q = (longint'(regs[CFG_ALT_GAIN]) * err) >>> 8;
					aerr = err < 0 ? -err : err;
					if (q > 128)
						q = 128;
					if (q < -128)
						q = -128;
					c.vz = 16'(q);
					altitude = clip16(longint'(altitude) + div10_round(q));
					if (aerr < int'(regs[CFG_ALT_TOL]) || e > CLIMB_TIMEOUT_TICKS)
						nxt = PH_TURN_A;
				end
				PH_TURN_A, PH_TURN_B, PH_TURN_C: begin
					c.wz = 16'(-int'(regs[CFG_TURN_RATE]));
					if (e > TURN_TICKS)
						nxt = cur_phase + 3'd1;
				end
				PH_SINE_XY, PH_SINE_Z: begin
					sv = sine_sample(regs[CFG_SINE_AMP], (regs[CFG_SINE_STEP] * e) & 'hFFFF);
					c.vx = 16'(signed_reg(CFG_FWD_SPEED));
					if (cur_phase == PH_SINE_XY)
						c.vy = 16'(sv);
					else
						c.vz = 16'(sv);
					if (e > SINE_TICKS)
						nxt = cur_phase + 3'd1;
				end
				PH_SPIRAL: begin
					r = div10_round(longint'(signed_reg(CFG_SPIRAL_SLOPE)) * longint'(e));
					c.vx = 16'(clip16(SPIRAL_START_SPEED + r));
					c.wz = 16'(clip16(SPIRAL_START_TURN + r));
					if (e > SPIRAL_TICKS)
						nxt = PH_TURN_C;
				end
				default: ;
			endcase
			if (nxt != cur_phase) begin
				cur_phase = nxt;
				elapsed = 0;
			end else begin
				elapsed = e;
			end
			c.ph = cur_phase;
			expected_cmds.push_back(c);
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_command(motion_cmd_t got);
			motion_cmd_t want;
			if (expected_cmds.size() == 0) begin
				$error("unexpected result transaction, phase %0d", got.ph);
				errors++;
				return;
			end
			want = expected_cmds.pop_front();
			compare_field("vel_x", want.vx, got.vx);
			compare_field("vel_y", want.vy, got.vy);
			compare_field("vel_z", want.vz, got.vz);
			compare_field("yaw_rate", want.wz, got.wz);
			compare_field("phase", want.ph, got.ph);
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [3:0]            ticks;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [15:0]    vel_x;
	logic signed [15:0]    vel_y;
	logic signed [15:0]    vel_z;
	logic signed [15:0]    yaw_rate;
	logic [2:0]            phase;

	pattern_scoreboard sb = new();
	logic [15:0] reg_vals [8];
	bit no_idle;
	bit hold_req;
	int sent;
	int cycle_count;

	timed_motion_pattern_sequencer #(
		.TURN_TICKS(TURN_TICKS),
		.SINE_TICKS(SINE_TICKS),
		.SPIRAL_TICKS(SPIRAL_TICKS),
		.CLIMB_TIMEOUT_TICKS(CLIMB_TIMEOUT_TICKS),
		.SPIRAL_START_SPEED(SPIRAL_START_SPEED),
		.SPIRAL_START_TURN(SPIRAL_START_TURN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ticks(ticks),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.vel_z(vel_z),
		.yaw_rate(yaw_rate),
		.phase(phase)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(input logic [3:0] t);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ticks <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.accept_ticks(t);
		sent++;
	endtask

	task automatic program_regs();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= reg_vals[i];
			sb.write_reg(CFG_IDX_W'(i), reg_vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// sender pauses until every result is back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_reg(logic [15:0] lo, logic [15:0] hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return 16'($urandom);
		endcase
	endfunction

	// small steps while the pattern runs keep each phase alive for many items
	function automatic logic [3:0] pick_ticks();
		if (sb.cur_phase != PH_HOVER && $urandom_range(0, 9) < 6)
			return 4'($urandom_range(0, 2));
		return 4'($urandom_range(0, 15));
	endfunction

	initial begin : receiver
		int stall;
		motion_cmd_t got;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 13);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got = '{vel_x, vel_y, vel_z, yaw_rate, phase};
			sb.check_command(got);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int seg;
		int seg_len;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		ticks <= '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// climb at full target and gain: clamped up, zero-tick transactions among the items
		reg_vals = '{16'd2560, 16'd4095, 16'd0, 16'd1023, 16'h0400, 16'd1023,
			16'hFFFF, 16'h0400};
		program_regs();
		send_item(4'd0);
		send_item(4'd1);
		send_item(4'd15);
		send_item(4'd0);
		send_item(4'd2);

		// target below altitude: negative error and floor rounding
		wait_idle();
		reg_vals[CFG_HOVER_HEIGHT] = 16'd0;
		reg_vals[CFG_ALT_GAIN] = 16'd255;
		program_regs();
		send_item(4'd0);
		send_item(4'd1);

		// zero gain holds altitude
		wait_idle();
		reg_vals[CFG_ALT_GAIN] = 16'd0;
		program_regs();
		send_item(4'd1);

		// upper register bits dropped; tiny gain
		wait_idle();
		reg_vals[CFG_HOVER_HEIGHT] = 16'hFFFF;
		reg_vals[CFG_ALT_GAIN] = 16'd1;
		reg_vals[CFG_ALT_TOL] = 16'd255;
		program_regs();
		send_item(4'd1);
		send_item(4'd1);
		// elapsed lands exactly on the timeout: still climbing
		send_item(4'd8);

		// target just above altitude: leaves climb on tolerance
		wait_idle();
		reg_vals[CFG_HOVER_HEIGHT] = 16'(sb.altitude + 10);
		reg_vals[CFG_ALT_GAIN] = 16'd256;
		reg_vals[CFG_ALT_TOL] = 16'd26;
		program_regs();
		send_item(4'd0);

		seg = 0;
		while (sent < NUM_ITEMS) begin
			wait_idle();
			foreach (reg_vals[i])
				reg_vals[i] = pick_reg(REG_LO[i], REG_HI[i]);
			program_regs();
			no_idle = ($urandom_range(0, 3) == 0);
			seg_len = $urandom_range(10, 60);
			// receiver holds off while the sender keeps pushing
			if (seg == 2) begin
				no_idle = 1'b1;
				hold_req = 1'b1;
				seg_len = 60;
			end
			repeat (seg_len) send_item(pick_ticks());
			seg++;
		end

		wait_idle();
		repeat (12) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
